// ===== hw/rtl/hpack_pkg.sv =====
// ----------------------------------------------------------------------------
// HPACK Huffman decoder package
// Canonical code tables, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package hpack_pkg;

    localparam int MAX_CODE_LEN = 30;
    localparam int OCTET_WIDTH = 8;
    localparam logic [8:0] EOS_SYMBOL = 9'd256;

    typedef enum logic [1:0] {
        KIND_SYMBOL  = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_BAD_PAD = 2'd2,
        KIND_BAD_CODE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_STATUS,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] kind;
        logic       last_of_run;
    } result_t;

    function automatic logic [4:0] len_count(input logic [4:0] len);
        logic [4:0] c;
        begin
            case (len)
                5'd5:  c = 5'd10;
                5'd6:  c = 5'd26;
                5'd7:  c = 5'd0;
                5'd8:  c = 5'd6;
                5'd10: c = 5'd5;
                5'd11: c = 5'd3;
                5'd12: c = 5'd2;
                5'd13: c = 5'd6;
                5'd14: c = 5'd2;
                5'd15: c = 5'd3;
                5'd19: c = 5'd3;
                5'd20: c = 5'd8;
                5'd21: c = 5'd13;
                5'd22: c = 5'd26;
                5'd23: c = 5'd29;
                5'd24: c = 5'd12;
                5'd25: c = 5'd4;
                5'd26: c = 5'd15;
                5'd27: c = 5'd19;
                5'd28: c = 5'd29;
                5'd30: c = 5'd4;
                default: c = 5'd0;
            endcase
            return c;
        end
    endfunction

    // length 7 holds 32 codes, beyond the 5-bit count
    function automatic logic [5:0] len_count6(input logic [4:0] len);
        begin
            return (len == 5'd7) ? 6'd32 : {1'b0, len_count(len)};
        end
    endfunction

    function automatic logic [8:0] sym_order(input logic [8:0] idx);
        logic [8:0] s;
        begin
            case (idx)
                9'd0: s = 9'd48; 9'd1: s = 9'd49; 9'd2: s = 9'd50; 9'd3: s = 9'd97;
                9'd4: s = 9'd99; 9'd5: s = 9'd101; 9'd6: s = 9'd105; 9'd7: s = 9'd111;
                9'd8: s = 9'd115; 9'd9: s = 9'd116;
                9'd10: s = 9'd32; 9'd11: s = 9'd37; 9'd12: s = 9'd45; 9'd13: s = 9'd46;
                9'd14: s = 9'd47; 9'd15: s = 9'd51; 9'd16: s = 9'd52; 9'd17: s = 9'd53;
                9'd18: s = 9'd54; 9'd19: s = 9'd55; 9'd20: s = 9'd56; 9'd21: s = 9'd57;
                9'd22: s = 9'd61; 9'd23: s = 9'd65; 9'd24: s = 9'd95; 9'd25: s = 9'd98;
                9'd26: s = 9'd100; 9'd27: s = 9'd102; 9'd28: s = 9'd103; 9'd29: s = 9'd104;
                9'd30: s = 9'd108; 9'd31: s = 9'd109; 9'd32: s = 9'd110; 9'd33: s = 9'd112;
                9'd34: s = 9'd114; 9'd35: s = 9'd117;
                9'd36: s = 9'd58; 9'd37: s = 9'd66; 9'd38: s = 9'd67; 9'd39: s = 9'd68;
                9'd40: s = 9'd69; 9'd41: s = 9'd70; 9'd42: s = 9'd71; 9'd43: s = 9'd72;
                9'd44: s = 9'd73; 9'd45: s = 9'd74; 9'd46: s = 9'd75; 9'd47: s = 9'd76;
                9'd48: s = 9'd77; 9'd49: s = 9'd78; 9'd50: s = 9'd79; 9'd51: s = 9'd80;
                9'd52: s = 9'd81; 9'd53: s = 9'd82; 9'd54: s = 9'd83; 9'd55: s = 9'd84;
                9'd56: s = 9'd85; 9'd57: s = 9'd86; 9'd58: s = 9'd87; 9'd59: s = 9'd89;
                9'd60: s = 9'd106; 9'd61: s = 9'd107; 9'd62: s = 9'd113; 9'd63: s = 9'd118;
                9'd64: s = 9'd119; 9'd65: s = 9'd120; 9'd66: s = 9'd121; 9'd67: s = 9'd122;
                9'd68: s = 9'd38; 9'd69: s = 9'd42; 9'd70: s = 9'd44; 9'd71: s = 9'd59;
                9'd72: s = 9'd88; 9'd73: s = 9'd90;
                9'd74: s = 9'd33; 9'd75: s = 9'd34; 9'd76: s = 9'd40; 9'd77: s = 9'd41;
                9'd78: s = 9'd63;
                9'd79: s = 9'd39; 9'd80: s = 9'd43; 9'd81: s = 9'd124;
                9'd82: s = 9'd35; 9'd83: s = 9'd62;
                9'd84: s = 9'd0; 9'd85: s = 9'd36; 9'd86: s = 9'd64; 9'd87: s = 9'd91;
                9'd88: s = 9'd93; 9'd89: s = 9'd126;
                9'd90: s = 9'd94; 9'd91: s = 9'd125;
                9'd92: s = 9'd60; 9'd93: s = 9'd96; 9'd94: s = 9'd123;
                9'd95: s = 9'd92; 9'd96: s = 9'd195; 9'd97: s = 9'd208;
                9'd98: s = 9'd128; 9'd99: s = 9'd130; 9'd100: s = 9'd131; 9'd101: s = 9'd162;
                9'd102: s = 9'd184; 9'd103: s = 9'd194; 9'd104: s = 9'd224; 9'd105: s = 9'd226;
                9'd106: s = 9'd153; 9'd107: s = 9'd161; 9'd108: s = 9'd167; 9'd109: s = 9'd172;
                9'd110: s = 9'd176; 9'd111: s = 9'd177; 9'd112: s = 9'd179; 9'd113: s = 9'd209;
                9'd114: s = 9'd216; 9'd115: s = 9'd217; 9'd116: s = 9'd227; 9'd117: s = 9'd229;
                9'd118: s = 9'd230;
                9'd119: s = 9'd129; 9'd120: s = 9'd132; 9'd121: s = 9'd133; 9'd122: s = 9'd134;
                9'd123: s = 9'd136; 9'd124: s = 9'd146; 9'd125: s = 9'd154; 9'd126: s = 9'd156;
                9'd127: s = 9'd160; 9'd128: s = 9'd163; 9'd129: s = 9'd164; 9'd130: s = 9'd169;
                9'd131: s = 9'd170; 9'd132: s = 9'd173; 9'd133: s = 9'd178; 9'd134: s = 9'd181;
                9'd135: s = 9'd185; 9'd136: s = 9'd186; 9'd137: s = 9'd187; 9'd138: s = 9'd189;
                9'd139: s = 9'd190; 9'd140: s = 9'd196; 9'd141: s = 9'd198; 9'd142: s = 9'd228;
                9'd143: s = 9'd232; 9'd144: s = 9'd233;
                9'd145: s = 9'd1; 9'd146: s = 9'd135; 9'd147: s = 9'd137; 9'd148: s = 9'd138;
                9'd149: s = 9'd139; 9'd150: s = 9'd140; 9'd151: s = 9'd141; 9'd152: s = 9'd143;
                9'd153: s = 9'd147; 9'd154: s = 9'd149; 9'd155: s = 9'd150; 9'd156: s = 9'd151;
                9'd157: s = 9'd152; 9'd158: s = 9'd155; 9'd159: s = 9'd157; 9'd160: s = 9'd158;
                9'd161: s = 9'd165; 9'd162: s = 9'd166; 9'd163: s = 9'd168; 9'd164: s = 9'd174;
                9'd165: s = 9'd175; 9'd166: s = 9'd180; 9'd167: s = 9'd182; 9'd168: s = 9'd183;
                9'd169: s = 9'd188; 9'd170: s = 9'd191; 9'd171: s = 9'd197; 9'd172: s = 9'd231;
                9'd173: s = 9'd239;
                9'd174: s = 9'd9; 9'd175: s = 9'd142; 9'd176: s = 9'd144; 9'd177: s = 9'd145;
                9'd178: s = 9'd148; 9'd179: s = 9'd159; 9'd180: s = 9'd171; 9'd181: s = 9'd206;
                9'd182: s = 9'd215; 9'd183: s = 9'd225; 9'd184: s = 9'd236; 9'd185: s = 9'd237;
                9'd186: s = 9'd199; 9'd187: s = 9'd207; 9'd188: s = 9'd234; 9'd189: s = 9'd235;
                9'd190: s = 9'd192; 9'd191: s = 9'd193; 9'd192: s = 9'd200; 9'd193: s = 9'd201;
                9'd194: s = 9'd202; 9'd195: s = 9'd205; 9'd196: s = 9'd210; 9'd197: s = 9'd213;
                9'd198: s = 9'd218; 9'd199: s = 9'd219; 9'd200: s = 9'd238; 9'd201: s = 9'd240;
                9'd202: s = 9'd242; 9'd203: s = 9'd243; 9'd204: s = 9'd255;
                9'd205: s = 9'd203; 9'd206: s = 9'd204; 9'd207: s = 9'd211; 9'd208: s = 9'd212;
                9'd209: s = 9'd214; 9'd210: s = 9'd221; 9'd211: s = 9'd222; 9'd212: s = 9'd223;
                9'd213: s = 9'd241; 9'd214: s = 9'd244; 9'd215: s = 9'd245; 9'd216: s = 9'd246;
                9'd217: s = 9'd247; 9'd218: s = 9'd248; 9'd219: s = 9'd250; 9'd220: s = 9'd251;
                9'd221: s = 9'd252; 9'd222: s = 9'd253; 9'd223: s = 9'd254;
                9'd224: s = 9'd2; 9'd225: s = 9'd3; 9'd226: s = 9'd4; 9'd227: s = 9'd5;
                9'd228: s = 9'd6; 9'd229: s = 9'd7; 9'd230: s = 9'd8; 9'd231: s = 9'd11;
                9'd232: s = 9'd12; 9'd233: s = 9'd14; 9'd234: s = 9'd15; 9'd235: s = 9'd16;
                9'd236: s = 9'd17; 9'd237: s = 9'd18; 9'd238: s = 9'd19; 9'd239: s = 9'd20;
                9'd240: s = 9'd21; 9'd241: s = 9'd23; 9'd242: s = 9'd24; 9'd243: s = 9'd25;
                9'd244: s = 9'd26; 9'd245: s = 9'd27; 9'd246: s = 9'd28; 9'd247: s = 9'd29;
                9'd248: s = 9'd30; 9'd249: s = 9'd31; 9'd250: s = 9'd127; 9'd251: s = 9'd220;
                9'd252: s = 9'd249;
                9'd253: s = 9'd10; 9'd254: s = 9'd13; 9'd255: s = 9'd22; 9'd256: s = 9'd256;
                default: s = 9'd0;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== hw/rtl/hpack_huffman_decoder.sv =====
// ----------------------------------------------------------------------------
// HPACK Huffman decoder
// Decodes an RFC 7541 Huffman string one octet at a time.
// A symbol is held until the next code or the end of the scan says whether it ends
// the run. Each octet is scanned by the one-length-per-cycle canonical compare unit,
// and no new octet is accepted until that scan is done; after a bad code, octets
// are discarded at one octet per cycle. Each result also waits for m_tready.
// Reset clears accumulator, count and error flag.
// ----------------------------------------------------------------------------
module hpack_huffman_decoder #(
    parameter int ACCUM_BITS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_octet
    input  logic        s_tlast,   // final_octet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // symbol
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last_of_run
);

    localparam int CW = $clog2(ACCUM_BITS + 1);

    hpack_pkg::state_t state_reg, state_next;
    logic [ACCUM_BITS-1:0] acc_reg, acc_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           err_reg, err_next;
    logic           fin_reg, fin_next;
    logic [1:0]     nsym_reg, nsym_next;
    logic [4:0]     len_reg, len_next;
    logic [29:0]    first_reg, first_next;
    logic [8:0]     off_reg, off_next;
    logic [8:0]     hit_idx_reg, hit_idx_next;
    logic           ov_reg, ov_next;
    logic           hold_v_reg, hold_v_next;
    logic [7:0]     hold_sym_reg, hold_sym_next;
    hpack_pkg::result_t res_reg, res_next;

    logic [29:0] head_bits;
    logic [ACCUM_BITS+29:0] ext;
    logic        u_hit;
    logic [8:0]  u_idx;
    logic [29:0] u_first;
    logic [8:0]  u_off;
    logic [8:0]  sym9;
    logic [7:0]  pad_ones;
    logic        pad_ok;
    logic        fire_in;
    logic        no_code;

    // head 30 bits, left aligned, zero filled below count
    always_comb
    begin
        ext = {acc_reg, 30'd0} >> cnt_reg;
        head_bits = ext[29:0];
    end

    hpack_canon_step u_step (
        .len         (len_reg),
        .head_bits   (head_bits),
        .first_code  (first_reg),
        .offset      (off_reg),
        .hit         (u_hit),
        .symbol_index(u_idx),
        .first_next  (u_first),
        .offset_next (u_off)
    );

    assign sym9 = hpack_pkg::sym_order(hit_idx_reg);
    assign pad_ones = 8'((16'd1 << cnt_reg[2:0]) - 16'd1);
    assign pad_ok = (cnt_reg <= CW'(7)) && (acc_reg[7:0] == pad_ones);
    assign fire_in = s_tvalid && s_tready;
    assign no_code = ({1'b0, len_reg} > 6'(cnt_reg)) || (len_reg > 5'd30);

    assign s_tready = (state_reg == hpack_pkg::ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata = res_reg.symbol;
    assign m_tuser = res_reg.kind;
    assign m_tlast = res_reg.last_of_run;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpack_pkg::ST_IDLE:
            begin
                if (fire_in)
                begin
                    state_next = err_reg ? hpack_pkg::ST_IDLE : hpack_pkg::ST_SCAN;
                end
            end
            hpack_pkg::ST_SCAN:
            begin
                if (no_code)
                begin
                    if (fin_reg)
                    begin
                        state_next = hpack_pkg::ST_STATUS;
                    end
                    else
                    begin
                        state_next = hold_v_reg ? hpack_pkg::ST_HOLD : hpack_pkg::ST_IDLE;
                    end
                end
                else if (u_hit)
                begin
                    state_next = hpack_pkg::ST_EMIT;
                end
            end
            hpack_pkg::ST_EMIT:
            begin
                if (sym9 == hpack_pkg::EOS_SYMBOL)
                begin
                    if (!ov_reg && !hold_v_reg)
                    begin
                        state_next = hpack_pkg::ST_IDLE;
                    end
                end
                else if (nsym_reg == 2'd0)
                begin
                    state_next = hpack_pkg::ST_SCAN;
                end
                else if (!ov_reg)
                begin
                    state_next = fin_reg ? hpack_pkg::ST_STATUS : hpack_pkg::ST_HOLD;
                end
            end
            hpack_pkg::ST_STATUS:
            begin
                if (!ov_reg && !hold_v_reg)
                begin
                    state_next = hpack_pkg::ST_IDLE;
                end
            end
            hpack_pkg::ST_HOLD:
            begin
                if (!ov_reg)
                begin
                    state_next = hpack_pkg::ST_IDLE;
                end
            end
            default: state_next = hpack_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        fin_next = fin_reg;
        nsym_next = nsym_reg;
        len_next = len_reg;
        first_next = first_reg;
        off_next = off_reg;
        hit_idx_next = hit_idx_reg;
        hold_v_next = hold_v_reg;
        hold_sym_next = hold_sym_reg;
        ov_next = ov_reg && !m_tready;
        res_next = res_reg;
        case (state_reg)
            hpack_pkg::ST_IDLE:
            begin
                if (fire_in)
                begin
                    fin_next = s_tlast;
                    if (err_reg)
                    begin
                        if (s_tlast)
                        begin
                            err_next = 1'b0;
                            acc_next = '0;
                            cnt_next = '0;
                        end
                    end
                    else
                    begin
                        acc_next = {acc_reg[ACCUM_BITS-hpack_pkg::OCTET_WIDTH-1:0], s_tdata};
                        cnt_next = cnt_reg + CW'(hpack_pkg::OCTET_WIDTH);
                        nsym_next = 2'd0;
                        len_next = 5'd1;
                        first_next = '0;
                        off_next = '0;
                    end
                end
            end
            hpack_pkg::ST_SCAN:
            begin
                if (no_code)
                begin
                end
                else if (u_hit)
                begin
                    hit_idx_next = u_idx;
                end
                else
                begin
                    len_next = len_reg + 5'd1;
                    first_next = u_first;
                    off_next = u_off;
                end
            end
            hpack_pkg::ST_EMIT:
            begin
                if (sym9 == hpack_pkg::EOS_SYMBOL)
                begin
                    if (!ov_reg)
                    begin
                        ov_next = 1'b1;
                        if (hold_v_reg)
                        begin
                            res_next.symbol = hold_sym_reg;
                            res_next.kind = hpack_pkg::KIND_SYMBOL;
                            res_next.last_of_run = 1'b0;
                            hold_v_next = 1'b0;
                        end
                        else
                        begin
                            res_next.symbol = 8'd0;
                            res_next.kind = hpack_pkg::KIND_BAD_CODE;
                            res_next.last_of_run = 1'b1;
                            acc_next = '0;
                            cnt_next = '0;
                            err_next = !fin_reg;
                        end
                    end
                end
                else if (nsym_reg == 2'd0)
                begin
                    hold_v_next = 1'b1;
                    hold_sym_next = sym9[7:0];
                    cnt_next = cnt_reg - CW'(len_reg);
                    acc_next = acc_reg & ((ACCUM_BITS'(1) << (cnt_reg - CW'(len_reg)))
                               - ACCUM_BITS'(1));
                    nsym_next = 2'd1;
                    len_next = 5'd1;
                    first_next = '0;
                    off_next = '0;
                end
                else if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    res_next.symbol = hold_sym_reg;
                    res_next.kind = hpack_pkg::KIND_SYMBOL;
                    res_next.last_of_run = 1'b0;
                    hold_v_next = 1'b1;
                    hold_sym_next = sym9[7:0];
                    cnt_next = cnt_reg - CW'(len_reg);
                    acc_next = acc_reg & ((ACCUM_BITS'(1) << (cnt_reg - CW'(len_reg)))
                               - ACCUM_BITS'(1));
                    nsym_next = 2'd2;
                end
            end
            hpack_pkg::ST_STATUS:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    if (hold_v_reg)
                    begin
                        res_next.symbol = hold_sym_reg;
                        res_next.kind = hpack_pkg::KIND_SYMBOL;
                        res_next.last_of_run = 1'b0;
                        hold_v_next = 1'b0;
                    end
                    else
                    begin
                        res_next.symbol = 8'd0;
                        res_next.kind = pad_ok ? hpack_pkg::KIND_END_OK
                                               : hpack_pkg::KIND_BAD_PAD;
                        res_next.last_of_run = 1'b1;
                        acc_next = '0;
                        cnt_next = '0;
                        err_next = 1'b0;
                    end
                end
            end
            hpack_pkg::ST_HOLD:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    res_next.symbol = hold_sym_reg;
                    res_next.kind = hpack_pkg::KIND_SYMBOL;
                    res_next.last_of_run = 1'b1;
                    hold_v_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hpack_pkg::ST_IDLE;
            acc_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
            ov_reg <= 1'b0;
            fin_reg <= 1'b0;
            nsym_reg <= 2'd0;
            len_reg <= 5'd1;
            first_reg <= '0;
            off_reg <= '0;
            hit_idx_reg <= '0;
            hold_v_reg <= 1'b0;
            hold_sym_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            ov_reg <= ov_next;
            fin_reg <= fin_next;
            nsym_reg <= nsym_next;
            len_reg <= len_next;
            first_reg <= first_next;
            off_reg <= off_next;
            hit_idx_reg <= hit_idx_next;
            hold_v_reg <= hold_v_next;
            hold_sym_reg <= hold_sym_next;
            res_reg <= res_next;
        end
    end

endmodule

// ===== hw/rtl/hpack_canon_step.sv =====
// ----------------------------------------------------------------------------
// HPACK canonical code step
// One code length per cycle: compare the head bits against the first code
// of that length and advance the canonical first code and table offset.
// ----------------------------------------------------------------------------
module hpack_canon_step (
    input  logic [4:0]  len,
    input  logic [29:0] head_bits,
    input  logic [29:0] first_code,
    input  logic [8:0]  offset,
    output logic        hit,
    output logic [8:0]  symbol_index,
    output logic [29:0] first_next,
    output logic [8:0]  offset_next
);

    logic [29:0] cand;
    logic [29:0] diff;
    logic [5:0]  cnt;
    logic [29:0] sum;

    always_comb
    begin
        cnt = hpack_pkg::len_count6(len);
        cand = head_bits >> (5'd30 - len);
        diff = cand - first_code;
        hit = (cand >= first_code) && (diff < {24'd0, cnt});
        symbol_index = offset + diff[8:0];
        sum = first_code + {24'd0, cnt};
        first_next = {sum[28:0], 1'b0};
        offset_next = offset + {3'd0, cnt};
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// HPACK Huffman decoder testbench
// Feeds well-formed, badly padded, EOS-carrying and random-octet strings
// through the decoder under varied backpressure. Each item is checked against
// an in-bench canonical decoder.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    hpack_huffman_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    int code_count [31] = '{0, 0, 0, 0, 0, 10, 26, 32, 6, 0, 5, 3, 2, 6, 2, 3,
                            0, 0, 0, 3, 8, 13, 26, 29, 12, 4, 15, 19, 29, 0, 4};

    int canon_syms [257] = '{
        48, 49, 50, 97, 99, 101, 105, 111, 115, 116,
        32, 37, 45, 46, 47, 51, 52, 53, 54, 55, 56, 57, 61, 65, 95,
        98, 100, 102, 103, 104, 108, 109, 110, 112, 114, 117,
        58, 66, 67, 68, 69, 70, 71, 72, 73, 74, 75, 76, 77, 78, 79,
        80, 81, 82, 83, 84, 85, 86, 87, 89, 106, 107, 113, 118, 119,
        120, 121, 122,
        38, 42, 44, 59, 88, 90,
        33, 34, 40, 41, 63,
        39, 43, 124,
        35, 62,
        0, 36, 64, 91, 93, 126,
        94, 125,
        60, 96, 123,
        92, 195, 208,
        128, 130, 131, 162, 184, 194, 224, 226,
        153, 161, 167, 172, 176, 177, 179, 209, 216, 217, 227, 229, 230,
        129, 132, 133, 134, 136, 146, 154, 156, 160, 163, 164, 169, 170,
        173, 178, 181, 185, 186, 187, 189, 190, 196, 198, 228, 232, 233,
        1, 135, 137, 138, 139, 140, 141, 143, 147, 149, 150, 151, 152,
        155, 157, 158, 165, 166, 168, 174, 175, 180, 182, 183, 188, 191,
        197, 231, 239,
        9, 142, 144, 145, 148, 159, 171, 206, 215, 225, 236, 237,
        199, 207, 234, 235,
        192, 193, 200, 201, 202, 205, 210, 213, 218, 219, 238, 240, 242,
        243, 255,
        203, 204, 211, 212, 214, 221, 222, 223, 241, 244, 245, 246, 247,
        248, 250, 251, 252, 253, 254,
        2, 3, 4, 5, 6, 7, 8, 11, 12, 14, 15, 16, 17, 18, 19, 20, 21,
        23, 24, 25, 26, 27, 28, 29, 30, 31, 127, 220, 249,
        10, 13, 22, 256
    };

    // encoder view of the same code: word and length per symbol
    logic [29:0] sym_code [257];
    int          sym_len  [257];

    class huffman_scoreboard;
        hpack_pkg::result_t pending_q[$];
        logic [63:0] acc;
        int          nbits;
        bit          in_error;
        int          errors;

        function new();
            acc = '0;
            nbits = 0;
            in_error = 0;
            errors = 0;
        endfunction

        function int head_word(output int sym);
            logic [63:0] first;
            logic [63:0] v;
            int          offset;
            first = '0;
            offset = 0;
            sym = 0;
            for (int len = 1; len <= 30 && len <= nbits; len++) begin
                v = (acc >> (nbits - len)) & ((64'd1 << len) - 1);
                if (v >= first && v - first < code_count[len]) begin
                    sym = canon_syms[offset + int'(v - first)];
                    return len;
                end
                offset += code_count[len];
                first = (first + 64'(code_count[len])) << 1;
            end
            return 0;
        endfunction

        function void note_octet(logic [7:0] octet, logic fin);
            hpack_pkg::result_t r;
            hpack_pkg::result_t run_q[$];
            int      len;
            int      sym;
            bit      bad;
            bit      ok;
            bad = 0;
            if (in_error) begin
                if (fin)
                begin
                    acc = '0;
                    nbits = 0;
                    in_error = 0;
                end
                return;
            end
            acc = ((acc << 8) | 64'(octet)) & ((64'd1 << 40) - 1);
            nbits += 8;
            while (run_q.size() < 2) begin
                len = head_word(sym);
                if (len == 0)
                    break;
                if (sym == int'(hpack_pkg::EOS_SYMBOL))
                begin
                    bad = 1;
                    break;
                end
                r.symbol = sym[7:0];
                r.kind = hpack_pkg::KIND_SYMBOL;
                r.last_of_run = 1'b0;
                run_q.push_back(r);
                nbits -= len;
                acc &= (64'd1 << nbits) - 1;
            end
            if (bad || fin)
            begin
                ok = nbits <= 7 && acc == (64'd1 << nbits) - 1;
                r.symbol = 8'd0;
                r.kind = bad ? hpack_pkg::KIND_BAD_CODE :
                         (ok ? hpack_pkg::KIND_END_OK : hpack_pkg::KIND_BAD_PAD);
                r.last_of_run = 1'b0;
                run_q.push_back(r);
                acc = '0;
                nbits = 0;
                in_error = bad && !fin;
            end
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last_of_run = 1'b1;
            foreach (run_q[i])
                pending_q.push_back(run_q[i]);
        endfunction

        function void check_result(logic [7:0] symbol, logic [1:0] kind, logic last);
            hpack_pkg::result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result symbol=%0d kind=%0d last=%0b",
                         $time, symbol, kind, last);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (symbol !== e.symbol)
            begin
                $display("%0t: symbol expected %0d actual %0d", $time, e.symbol, symbol);
                errors++;
            end
            if (kind !== e.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
                errors++;
            end
            if (last !== e.last_of_run)
            begin
                $display("%0t: last expected %0b actual %0b", $time, e.last_of_run, last);
                errors++;
            end
        endfunction
    endclass

    huffman_scoreboard sb;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    int   cycles;
    int   items_sent;
    logic [8:0] octet_q[$];   // {last, octet}

    localparam int STR_GOOD = 0;
    localparam int STR_BAD_PAD = 1;
    localparam int STR_EOS = 2;
    localparam int STR_NOISE = 3;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);

    function automatic int pick_symbol();
        if ($urandom_range(99) < 60)
            return canon_syms[$urandom_range(73)];
        return $urandom_range(255);
    endfunction

    // build one coded string into octet_q
    task automatic build_string(int mode, int syms[$]);
        bit bits[$];
        int eos_at;
        int n;
        logic [7:0] o;
        eos_at = (mode == STR_EOS) ? $urandom_range(syms.size()) : -1;
        if (mode == STR_NOISE)
        begin
            n = syms.size();
            for (int i = 0; i < n; i++)
                octet_q.push_back({(i == n - 1) ? 1'b1 : 1'b0, 8'($urandom)});
            return;
        end
        for (int i = 0; i <= syms.size(); i++) begin
            if (i == eos_at)
                for (int b = sym_len[256] - 1; b >= 0; b--)
                    bits.push_back(sym_code[256][b]);
            if (i < syms.size())
                for (int b = sym_len[syms[i]] - 1; b >= 0; b--)
                    bits.push_back(sym_code[syms[i]][b]);
        end
        if (mode == STR_BAD_PAD && (bits.size() % 8 != 0) && $urandom_range(1))
            while (bits.size() % 8 != 0)
                bits.push_back(1'b0);
        else
        begin
            while (bits.size() % 8 != 0)
                bits.push_back(1'b1);
            if (mode == STR_BAD_PAD || bits.size() == 0)
                repeat (8) bits.push_back(1'b1);
        end
        n = bits.size() / 8;
        for (int i = 0; i < n; i++) begin
            for (int b = 0; b < 8; b++)
                o[7 - b] = bits[i * 8 + b];
            octet_q.push_back({(i == n - 1) ? 1'b1 : 1'b0, o});
        end
    endtask

    task automatic send_all();
        logic [8:0] it;
        while (octet_q.size() > 0) begin
            it = octet_q.pop_front();
            while ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= it[7:0];
            s_tlast <= it[8];
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            sb.note_octet(it[7:0], it[8]);
            items_sent++;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_string();
        int syms[$];
        int mode;
        int r;
        r = $urandom_range(99);
        mode = (r < 70) ? STR_GOOD : (r < 80) ? STR_BAD_PAD : (r < 90) ? STR_EOS : STR_NOISE;
        repeat ($urandom_range(1, 8)) syms.push_back(pick_symbol());
        build_string(mode, syms);
        send_all();
    endtask

    initial
    begin
        logic [29:0] first;
        int          offset;
        int          syms[$];
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        cycles = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        first = '0;
        offset = 0;
        for (int len = 1; len <= 30; len++) begin
            for (int i = 0; i < code_count[len]; i++) begin
                sym_code[canon_syms[offset + i]] = first + 30'(i);
                sym_len[canon_syms[offset + i]] = len;
            end
            offset += code_count[len];
            first = (first + 30'(code_count[len])) << 1;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: raw extremes, padding limits, EOS, errors on final
        octet_q.push_back({1'b1, 8'hFF});
        octet_q.push_back({1'b1, 8'h00});
        octet_q.push_back({1'b0, 8'h00});
        octet_q.push_back({1'b1, 8'hFF});
        send_all();
        syms = '{48, 49, 97, 116};
        build_string(STR_GOOD, syms);
        syms = '{10, 13, 22, 255};
        build_string(STR_GOOD, syms);
        syms = '{0, 92, 127};
        build_string(STR_BAD_PAD, syms);
        syms = '{48, 50};
        build_string(STR_EOS, syms);
        send_all();
        // EOS spanning the final octet
        octet_q.push_back({1'b0, 8'hFF});
        octet_q.push_back({1'b0, 8'hFF});
        octet_q.push_back({1'b0, 8'hFF});
        octet_q.push_back({1'b1, 8'hFF});
        send_all();
        drain();

        // long receiver hold-off while one long string is offered
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
        join_none
        syms = {};
        repeat (40) syms.push_back(pick_symbol());
        build_string(STR_GOOD, syms);
        send_all();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 10 : 87) : 0;
            recv_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 10 : 0;
            while (items_sent < 10 + (phase + 1) * 90)
                random_string();
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (200) @(posedge clk);
        while (sb.pending_q.size() > 0) begin
            $display("%0t: missing result kind expected %0d actual none",
                     $time, sb.pending_q[0].kind);
            void'(sb.pending_q.pop_front());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/hpack_pkg.sv
hw/rtl/hpack_canon_step.sv
hw/rtl/hpack_huffman_decoder.sv
tb/tb.sv
